FILE: rtl/lgud_pkg.sv
// Shared constants and types for the linear glide block.
// No dependencies; the top level imports it and the interfaces use its widths.
package lgud_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int FRAC_BITS      = 16;
	localparam int LENGTH_BITS    = 16;
	localparam int RECIP_BITS     = 24;
	localparam int CFG_DATA_BITS  = 24;
	localparam int CFG_INDEX_BITS = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_RISE_LENGTH = 2'd0,
		REG_FALL_LENGTH = 2'd1,
		REG_RISE_RECIP  = 2'd2,
		REG_FALL_RECIP  = 2'd3
	} cfg_reg_t;

endpackage

FILE: rtl/lgud_if.sv
// Valid/ready channel interfaces for the linear glide block: target samples,
// glided samples and register writes. Depends on lgud_pkg for default widths.
interface lgud_target_if #(parameter int SAMPLE_BITS = lgud_pkg::SAMPLE_BITS);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, sample_in, input ready);
	modport sink (input valid, sample_in, output ready);
endinterface

interface lgud_result_if #(parameter int SAMPLE_BITS = lgud_pkg::SAMPLE_BITS);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, sample_out, input ready);
	modport sink (input valid, sample_out, output ready);
endinterface

interface lgud_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [lgud_pkg::CFG_INDEX_BITS-1:0]    index;
	logic [lgud_pkg::CFG_DATA_BITS-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/linear_glide_up_down.sv
// Linear glide with separate rise and fall ramp lengths, top level.
// Depends on lgud_pkg and the channel interfaces in lgud_if.sv.
//
// Usage: target samples arrive on the target channel and one glided sample
// leaves on the result channel for each of them, in order. A sample that
// differs from the stored goal (or the first one after a length register is
// written) starts a straight ramp from the present output, using the rise or
// fall length and reciprocal; lengths of 0 or 1 jump to the goal at once.
// Registers are written over the cfg channel, which is always ready; write
// them only while no sample is in flight.
// A target transfer loads the input register, and the ramp arithmetic (one
// split multiply, the level add and saturation) fills the result register
// from it once the result register is free. A new sample can be taken every
// cycle while the receiver keeps result.ready high; the rate is bounded by
// the level update loop through level_q.
// When the receiver stalls, the result register holds and the input register
// absorbs one more sample before target.ready falls.
// Reset clears the configuration, the ramp state and both valid flags, and
// arms the retarget flag so that the first sample always sets the goal.
module linear_glide_up_down #(
	parameter int SAMPLE_BITS = lgud_pkg::SAMPLE_BITS,
	parameter int FRAC_BITS   = lgud_pkg::FRAC_BITS,
	parameter int LENGTH_BITS = lgud_pkg::LENGTH_BITS
) (
	input  logic clk,
	input  logic arst_n,
	lgud_target_if.sink   target,
	lgud_result_if.source result,
	lgud_cfg_if.sink      cfg
);
	import lgud_pkg::*;

	localparam int LEVEL_BITS = SAMPLE_BITS + FRAC_BITS;
	localparam int MAG_BITS   = LEVEL_BITS + 1;
	localparam int LO_BITS    = (MAG_BITS + 1) / 2;
	localparam int HI_BITS    = MAG_BITS - LO_BITS;
	localparam int PROD_BITS  = MAG_BITS + RECIP_BITS;
	localparam int SUM_BITS   = LEVEL_BITS + 2;

	// Configuration
	logic [LENGTH_BITS-1:0] rise_len_q, fall_len_q;
	logic [RECIP_BITS-1:0]  rise_recip_q, fall_recip_q;

	// Glide state
	logic signed [LEVEL_BITS-1:0]  level_q;
	logic signed [SAMPLE_BITS-1:0] goal_q;
	logic signed [MAG_BITS-1:0]    step_q;
	logic [LENGTH_BITS-1:0]        steps_left_q;
	logic                          retarget_q;

	// Pipeline
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          result_valid_q;
	logic signed [SAMPLE_BITS-1:0] result_q;

	logic out_free, s1_free, advance;

	logic signed [LEVEL_BITS-1:0]  target_fx, goal_fx;
	logic                          new_goal, rising, falling, ramp;
	logic [LENGTH_BITS-1:0]        sel_len;
	logic [RECIP_BITS-1:0]         sel_recip;
	logic signed [MAG_BITS-1:0]    diff;
	logic                          diff_neg;
	logic [MAG_BITS-1:0]           mag;
	logic [LO_BITS+RECIP_BITS-1:0] prod_lo;
	logic [HI_BITS+RECIP_BITS-1:0] prod_hi;
	logic [PROD_BITS-1:0]          prod;
	logic [MAG_BITS-1:0]           step_mag;
	logic signed [MAG_BITS-1:0]    step_new, step_add;
	logic signed [SUM_BITS-1:0]    sum;
	logic [2:0]                    sum_top;
	logic signed [LEVEL_BITS-1:0]  level_sat;

	logic signed [LEVEL_BITS-1:0]  level_n;
	logic signed [SAMPLE_BITS-1:0] goal_n, out_n;
	logic signed [MAG_BITS-1:0]    step_n;
	logic [LENGTH_BITS-1:0]        steps_n;
	logic                          retarget_n;
	logic                          len_write;

	assign out_free      = !result_valid_q || result.ready;
	assign s1_free       = !valid_s1 || out_free;
	assign advance       = valid_s1 && out_free;
	assign target.ready  = s1_free;
	assign result.valid  = result_valid_q;
	assign result.sample_out = result_q;
	assign cfg.ready     = 1'b1;

	// A write to either length register rearms the retarget flag.
	assign len_write = cfg.valid
		&& (cfg_reg_t'(cfg.index) inside {REG_RISE_LENGTH, REG_FALL_LENGTH});

	assign target_fx = {sample_s1, {FRAC_BITS{1'b0}}};
	assign goal_fx   = {goal_q, {FRAC_BITS{1'b0}}};
	assign new_goal  = (sample_s1 != goal_q) || retarget_q;
	assign rising    = target_fx > level_q;
	assign falling   = target_fx < level_q;
	assign sel_len   = rising ? rise_len_q : (falling ? fall_len_q : '0);
	assign sel_recip = rising ? rise_recip_q : (falling ? fall_recip_q : '0);
	assign ramp      = sel_len > LENGTH_BITS'(1);

	// Step = sign(d) * floor(|d| * recip / 2^RECIP_BITS), with |d| split in
	// two halves so that each multiplier stays narrow.
	assign diff     = {target_fx[LEVEL_BITS-1], target_fx} - {level_q[LEVEL_BITS-1], level_q};
	assign diff_neg = diff[MAG_BITS-1];
	assign mag      = diff_neg ? MAG_BITS'(-diff) : MAG_BITS'(diff);
	assign prod_lo  = mag[LO_BITS-1:0] * sel_recip;
	assign prod_hi  = mag[MAG_BITS-1:LO_BITS] * sel_recip;
	assign prod     = {prod_hi, {LO_BITS{1'b0}}} + PROD_BITS'(prod_lo);
	assign step_mag = prod[PROD_BITS-1:RECIP_BITS];
	assign step_new = diff_neg ? -$signed(step_mag) : $signed(step_mag);
	assign step_add = new_goal ? step_new : step_q;

	// One adder serves both the first step of a ramp and the running ramp.
	assign sum     = SUM_BITS'(level_q) + SUM_BITS'(step_add);
	assign sum_top = sum[SUM_BITS-1:LEVEL_BITS-1];
	always_comb begin
		if (sum_top == 3'b000 || sum_top == 3'b111) begin
			level_sat = sum[LEVEL_BITS-1:0];
		end else if (sum[SUM_BITS-1]) begin
			level_sat = {1'b1, {(LEVEL_BITS-1){1'b0}}};
		end else begin
			level_sat = {1'b0, {(LEVEL_BITS-1){1'b1}}};
		end
	end

	always_comb begin
		level_n    = level_q;
		goal_n     = goal_q;
		step_n     = step_q;
		steps_n    = steps_left_q;
		retarget_n = retarget_q;
		out_n      = goal_q;
		if (new_goal) begin
			goal_n     = sample_s1;
			retarget_n = 1'b0;
			if (ramp) begin
				step_n  = step_new;
				steps_n = sel_len;
				level_n = level_sat;
			end else begin
				step_n  = '0;
				steps_n = '0;
				level_n = target_fx;
			end
			out_n = level_n[LEVEL_BITS-1:FRAC_BITS];
		end else if (steps_left_q != '0) begin
			level_n = level_sat;
			out_n   = level_sat[LEVEL_BITS-1:FRAC_BITS];
			steps_n = steps_left_q - LENGTH_BITS'(1);
			// On the last but one step the level lands exactly on the goal.
			if (steps_n == LENGTH_BITS'(1)) begin
				step_n  = '0;
				level_n = goal_fx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_len_q     <= '0;
			fall_len_q     <= '0;
			rise_recip_q   <= '0;
			fall_recip_q   <= '0;
			level_q        <= '0;
			goal_q         <= '0;
			step_q         <= '0;
			steps_left_q   <= '0;
			retarget_q     <= 1'b1;
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= target.valid;
			end
			if (out_free) begin
				result_valid_q <= valid_s1;
			end
			if (advance) begin
				level_q      <= level_n;
				goal_q       <= goal_n;
				step_q       <= step_n;
				steps_left_q <= steps_n;
			end
			if (len_write) begin
				retarget_q <= 1'b1;
			end else if (advance) begin
				retarget_q <= retarget_n;
			end
			if (cfg.valid) begin
				case (cfg_reg_t'(cfg.index))
					REG_RISE_LENGTH: rise_len_q <= cfg.data[LENGTH_BITS-1:0];
					REG_FALL_LENGTH: fall_len_q <= cfg.data[LENGTH_BITS-1:0];
					REG_RISE_RECIP: rise_recip_q <= cfg.data[RECIP_BITS-1:0];
					REG_FALL_RECIP: fall_recip_q <= cfg.data[RECIP_BITS-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && target.valid) begin
			sample_s1 <= target.sample_in;
		end
		if (advance) begin
			result_q <= out_n;
		end
	end

	// With one step or none left, the step is cleared and the level sits on
	// the goal.
	a_idle_step_zero: assert property (@(posedge clk) disable iff (!arst_n)
		steps_left_q <= LENGTH_BITS'(1) |-> step_q == '0)
		else $error("step size not cleared at the end of a ramp");

	a_idle_level_goal: assert property (@(posedge clk) disable iff (!arst_n)
		steps_left_q <= LENGTH_BITS'(1) |-> level_q == goal_fx)
		else $error("level not on the goal at the end of a ramp");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		target.valid && target.ready |=> valid_s1)
		else $error("accepted sample not held in the input register");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid_q)
		else $error("processed sample produced no result");

endmodule
